// ===== design/rmst_pkg.sv =====
package rmst_pkg;

	// tree geometry
	localparam int LEAVES   = 1024;
	localparam int LEAF_W   = $clog2(LEAVES);
	localparam int NODE_AW  = LEAF_W + 1;
	localparam int NODES    = 2 * LEAVES;
	localparam int IDX_W    = LEAF_W + 2;
	localparam int RANGE_W  = LEAF_W + 1;
	localparam int VALUE_W  = 32;

	localparam logic signed [VALUE_W-1:0] IDENTITY = VALUE_W'(1000000000);

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_W_RD,
		ST_W_UPD,
		ST_Q_TEST,
		ST_Q_LO,
		ST_Q_HICHK,
		ST_Q_HI
	} rmst_state_t;

	// node memory request from the sequencer
	typedef struct packed {
		logic                      we;
		logic [NODE_AW-1:0]        waddr;
		logic signed [VALUE_W-1:0] wdata;
		logic                      re;
		logic [NODE_AW-1:0]        raddr;
	} rmst_mem_req_t;

endpackage

// ===== design/range_min_segment_tree.sv =====
// range minimum tree over 1024 leaves with point update
//
// input channel: in_valid/in_ready, one transfer per item. opcode 0 writes
// new_value at leaf position and updates the minima up to the root; it
// gives no result. opcode 1 queries the minimum over [range_low, range_high)
// and gives one transfer on the output channel (out_valid/out_ready).
// range_high above 1024 is clipped; an empty range returns 1000000000.
//
// one item at a time: in_ready is high only while the sequencer is idle.
// a write does a leaf write, then a sibling read and a parent write for
// each of 10 levels. a query does up to two node reads per level on 11
// levels, each read going through the single read port of the node memory.
//
// after reset the node memory is swept to 1000000000, one node a cycle,
// all 2048 nodes, during which in_ready stays low. a query result waits in
// the output register while out_ready is low; new items are still taken,
// and a following query holds its result until the register is free.
module range_min_segment_tree
	import rmst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [LEAF_W-1:0]         position,
	input  logic signed [VALUE_W-1:0] new_value,
	input  logic [RANGE_W-1:0]        range_low,
	input  logic [RANGE_W-1:0]        range_high,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] min_value
);

	rmst_mem_req_t             mem_req;
	logic signed [VALUE_W-1:0] rd_data;
	logic                      done;
	logic signed [VALUE_W-1:0] result;
	logic                      out_free;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] min_value_q;

	// output slot can take a new result this cycle
	assign out_free = !out_valid_q || out_ready;

	rmst_node_ram u_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	rmst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.position   (position),
		.new_value  (new_value),
		.range_low  (range_low),
		.range_high (range_high),
		.out_free   (out_free),
		.done       (done),
		.result     (result),
		.mem_req    (mem_req),
		.rd_data    (rd_data)
	);

	// output register, holds the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			min_value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign min_value = min_value_q;

endmodule

// ===== design/rmst_node_ram.sv =====
module rmst_node_ram
	import rmst_pkg::*;
(
	input  logic                      clk,
	input  rmst_mem_req_t             req,
	output logic signed [VALUE_W-1:0] rd_data
);

	logic signed [VALUE_W-1:0] mem_q [NODES];
	logic signed [VALUE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/rmst_min_unit.sv =====
module rmst_min_unit
	import rmst_pkg::*;
(
	input  logic signed [VALUE_W-1:0] a,
	input  logic signed [VALUE_W-1:0] b,
	output logic signed [VALUE_W-1:0] y
);

	// signed minimum, a wins ties
	assign y = (b < a) ? b : a;

endmodule

// ===== design/rmst_ctrl.sv =====
module rmst_ctrl
	import rmst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [LEAF_W-1:0]         position,
	input  logic signed [VALUE_W-1:0] new_value,
	input  logic [RANGE_W-1:0]        range_low,
	input  logic [RANGE_W-1:0]        range_high,
	input  logic                      out_free,
	output logic                      done,
	output logic signed [VALUE_W-1:0] result,
	output rmst_mem_req_t             mem_req,
	input  logic signed [VALUE_W-1:0] rd_data
);

	localparam logic [IDX_W-1:0]   TREE_BASE  = IDX_W'(LEAVES);
	localparam logic [RANGE_W-1:0] RANGE_LIM  = RANGE_W'(LEAVES);

	rmst_state_t               state_q, state_d;
	logic [NODE_AW-1:0]        clr_q, clr_d;
	logic [NODE_AW-1:0]        node_q, node_d;
	logic [IDX_W-1:0]          lo_q, lo_d;
	logic [IDX_W-1:0]          hi_q, hi_d;
	logic signed [VALUE_W-1:0] acc_q, acc_d;
	logic signed [VALUE_W-1:0] min_y;
	logic [NODE_AW-1:0]        parent;
	logic [IDX_W-1:0]          hi_dec;
	logic [RANGE_W-1:0]        hi_clip;

	// one shared compare for both the update walk and the query walk
	rmst_min_unit u_min (
		.a (acc_q),
		.b (rd_data),
		.y (min_y)
	);

	assign parent  = {1'b0, node_q[NODE_AW-1:1]};
	assign hi_dec  = hi_q - 1'b1;
	assign hi_clip = (range_high > RANGE_LIM) ? RANGE_LIM : range_high;
	assign result  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		acc_q  <= acc_d;
	end

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		node_d   = node_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		acc_d    = acc_q;
		mem_req  = '0;
		in_ready = 1'b0;
		done     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				mem_req.wdata = IDENTITY;
				clr_d         = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_WRITE) begin
						mem_req.we    = 1'b1;
						mem_req.waddr = {1'b1, position};
						mem_req.wdata = new_value;
						node_d        = {1'b1, position};
						acc_d         = new_value;
						state_d       = ST_W_RD;
					end else begin
						acc_d = IDENTITY;
						if (range_low >= hi_clip) begin
							lo_d = '0;
							hi_d = '0;
						end else begin
							lo_d = {1'b0, range_low} + TREE_BASE;
							hi_d = {1'b0, hi_clip} + TREE_BASE;
						end
						state_d = ST_Q_TEST;
					end
				end
			end
			ST_W_RD: begin
				// fetch the sibling of the current node
				mem_req.re    = 1'b1;
				mem_req.raddr = node_q ^ NODE_AW'(1);
				state_d       = ST_W_UPD;
			end
			ST_W_UPD: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = parent;
				mem_req.wdata = min_y;
				acc_d         = min_y;
				node_d        = parent;
				state_d       = (parent == NODE_AW'(1)) ? ST_IDLE : ST_W_RD;
			end
			ST_Q_TEST: begin
				if (lo_q >= hi_q) begin
					if (out_free) begin
						done    = 1'b1;
						state_d = ST_IDLE;
					end
				end else if (lo_q[0]) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = lo_q[NODE_AW-1:0];
					state_d       = ST_Q_LO;
				end else if (hi_q[0]) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = hi_dec[NODE_AW-1:0];
					hi_d          = hi_dec;
					state_d       = ST_Q_HI;
				end else begin
					lo_d = lo_q >> 1;
					hi_d = hi_q >> 1;
				end
			end
			ST_Q_LO: begin
				acc_d   = min_y;
				lo_d    = lo_q + 1'b1;
				state_d = ST_Q_HICHK;
			end
			ST_Q_HICHK: begin
				if (hi_q[0]) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = hi_dec[NODE_AW-1:0];
					hi_d          = hi_dec;
					state_d       = ST_Q_HI;
				end else begin
					lo_d    = lo_q >> 1;
					hi_d    = hi_q >> 1;
					state_d = ST_Q_TEST;
				end
			end
			ST_Q_HI: begin
				acc_d   = min_y;
				lo_d    = lo_q >> 1;
				hi_d    = hi_q >> 1;
				state_d = ST_Q_TEST;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
